// ----- rtl/core/dpsd_pkg.sv -----
// ----------------------------------------------------------------------------
// dpsd_pkg
// Shared widths, limits and the result word layout of the double peak
// spectrum detector.
// ----------------------------------------------------------------------------
package dpsd_pkg;

    // sample and energy widths
    localparam int MAG_W       = 16;
    localparam int ENERGY_W    = 24;
    localparam int SUM_W       = ENERGY_W + 1;
    localparam int POS_OUT_W   = 8;
    localparam int FOUND_W     = 2;
    localparam int NUM_PEAKS   = 3;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 48;
    localparam int M_PAD_W     = M_TDATA_W - (1 + SUM_W + 2 * POS_OUT_W + FOUND_W);

    // saturation limit of one peak energy
    localparam logic [ENERGY_W-1:0] ENERGY_MAX = {ENERGY_W{1'b1}};

    // result word, detected in bit 0
    typedef struct packed {
        logic [M_PAD_W-1:0]   pad;
        logic [FOUND_W-1:0]   peaks_found;
        logic [POS_OUT_W-1:0] second_peak_pos;
        logic [POS_OUT_W-1:0] first_peak_pos;
        logic [SUM_W-1:0]     added_energy;
        logic                 detected;
    } t_result;

endpackage

// ----- rtl/core/double_peak_spectrum_detector.sv -----
// ----------------------------------------------------------------------------
// double_peak_spectrum_detector
// Loads one magnitude spectrum into a sample memory, extracts the three
// largest peaks by repeated passes over the memory and flags a pronounced,
// matched double peak.
// ----------------------------------------------------------------------------
// Usage: the slave stream carries one magnitude per word, bin 0 first, with
// tlast on the final bin. Words beyond SPECTRUM_LENGTH are dropped; tlast on
// such a word still starts the analysis. Loading takes one word per cycle.
// After the tlast word the input stalls while the analysis runs on the
// sample memory (one read port, one read per cycle): for each of the three
// peaks a full scan, a walk down each side, a sum and clear pass over the
// peak and a step state, then one result word.
// The master stream gives one word per spectrum from an output register; a
// waiting result does not block loading of the next spectrum, only the end
// of its analysis. Reset is synchronous and clears the control state; the
// sample memory needs no clearing, only loaded bins are read.
// ----------------------------------------------------------------------------
module double_peak_spectrum_detector #(
    parameter int SPECTRUM_LENGTH = 256
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // slave stream, tdata: magnitude[15:0]; tlast: last sample
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [dpsd_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input  logic                           s_axis_tlast,
    // master stream, tdata: detected[0], added_energy[25:1],
    // first_peak_pos[33:26], second_peak_pos[41:34], peaks_found[43:42]
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [dpsd_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    localparam int AW = $clog2(SPECTRUM_LENGTH);
    localparam int CW = $clog2(SPECTRUM_LENGTH + 1);
    localparam int PW = AW + 2;
    localparam int MW = dpsd_pkg::MAG_W;
    localparam int EW = dpsd_pkg::ENERGY_W;
    localparam int SW = dpsd_pkg::SUM_W;
    localparam int FW = dpsd_pkg::FOUND_W;
    localparam logic [CW-1:0] LEN_MAX = CW'(SPECTRUM_LENGTH);

    // state codes
    localparam logic [3:0] S_LOAD   = 4'd0;
    localparam logic [3:0] S_SCAN   = 4'd1;
    localparam logic [3:0] S_LSTART = 4'd2;
    localparam logic [3:0] S_WALKL  = 4'd3;
    localparam logic [3:0] S_RSTART = 4'd4;
    localparam logic [3:0] S_WALKR  = 4'd5;
    localparam logic [3:0] S_SUM    = 4'd6;
    localparam logic [3:0] S_NEXT   = 4'd7;
    localparam logic [3:0] S_DECIDE = 4'd8;

    // sample memory
    logic [MW-1:0] r_mem [SPECTRUM_LENGTH];
    logic [MW-1:0] r_rdata;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [MW-1:0] wr_data;

    logic [3:0]            r_state,    n_state;
    logic [CW-1:0]         r_cnt,      n_cnt;
    logic [CW-1:0]         r_len,      n_len;
    logic [1:0]            r_peak,     n_peak;
    logic [FW-1:0]         r_found,    n_found;
    logic [MW-1:0]         r_best,     n_best;
    logic [AW-1:0]         r_pos,      n_pos;
    logic [CW-1:0]         r_idx,      n_idx;
    logic                  r_rvalid,   n_rvalid;
    logic [AW-1:0]         r_ridx,     n_ridx;
    logic [AW-1:0]         r_lo,       n_lo;
    logic [AW-1:0]         r_hi,       n_hi;
    logic [MW-1:0]         r_cur,      n_cur;
    logic [EW-1:0]         r_sum,      n_sum;
    logic [2:0][EW-1:0]    r_energy,   n_energy;
    logic [2:0][AW-1:0]    r_position, n_position;
    dpsd_pkg::t_result     r_result,   n_result;
    logic                  r_m_valid,  n_m_valid;

    logic [SW-1:0]  sum_add;
    logic [AW-1:0]  lo_m1;
    logic [CW-1:0]  hi_p1;
    logic [CW-1:0]  hi_p2;
    logic [AW-1:0]  m1, m2, pos_d, pos_mn;
    logic [PW-1:0]  d2, d3, mn2, mn3;
    logic           energy_ok;
    logic           hit;

    assign s_axis_tready = (r_state == S_LOAD);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_result;

    // memory ports, registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    // helpers for walks and sum
    assign sum_add = {1'b0, r_sum} + SW'(r_rdata);
    assign lo_m1   = r_lo - AW'(1);
    assign hi_p1   = CW'(r_hi) + CW'(1);
    assign hi_p2   = CW'(r_hi) + CW'(2);

    // double peak decision
    assign m1        = r_position[0];
    assign m2        = r_position[1];
    assign pos_d     = (m1 > m2) ? (m1 - m2) : (m2 - m1);
    assign pos_mn    = (m1 < m2) ? m1 : m2;
    assign d2        = PW'(pos_d) << 1;
    assign d3        = (PW'(pos_d) << 1) + PW'(pos_d);
    assign mn2       = PW'(pos_mn) << 1;
    assign mn3       = (PW'(pos_mn) << 1) + PW'(pos_mn);
    assign energy_ok = ({1'b0, r_energy[0]} < {r_energy[1], 1'b0})
                    && ({1'b0, r_energy[1]} > {r_energy[2], 1'b0});
    assign hit       = energy_ok && (pos_mn != '0) && (d2 < mn3) && (d3 > mn2);

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_len      = r_len;
        n_peak     = r_peak;
        n_found    = r_found;
        n_best     = r_best;
        n_pos      = r_pos;
        n_idx      = r_idx;
        n_rvalid   = r_rvalid;
        n_ridx     = r_ridx;
        n_lo       = r_lo;
        n_hi       = r_hi;
        n_cur      = r_cur;
        n_sum      = r_sum;
        n_energy   = r_energy;
        n_position = r_position;
        n_result   = r_result;
        n_m_valid  = r_m_valid;
        rd_en      = 1'b0;
        rd_addr    = '0;
        wr_en      = 1'b0;
        wr_addr    = '0;
        wr_data    = '0;

        if (r_m_valid && m_axis_tready) begin
            n_m_valid = 1'b0;
        end

        case (r_state)
            // store samples until the last one
            S_LOAD: begin
                if (s_axis_tvalid) begin
                    if (r_cnt < LEN_MAX) begin
                        wr_en   = 1'b1;
                        wr_addr = r_cnt[AW-1:0];
                        wr_data = s_axis_tdata[MW-1:0];
                        n_cnt   = r_cnt + CW'(1);
                    end
                    if (s_axis_tlast) begin
                        n_len    = (r_cnt < LEN_MAX) ? (r_cnt + CW'(1)) : r_cnt;
                        n_cnt    = '0;
                        n_peak   = '0;
                        n_found  = '0;
                        n_idx    = '0;
                        n_best   = '0;
                        n_pos    = '0;
                        n_rvalid = 1'b0;
                        n_state  = S_SCAN;
                    end
                end
            end

            // find first maximum
            S_SCAN: begin
                if (r_idx != r_len) begin
                    rd_en    = 1'b1;
                    rd_addr  = r_idx[AW-1:0];
                    n_idx    = r_idx + CW'(1);
                    n_rvalid = 1'b1;
                    n_ridx   = r_idx[AW-1:0];
                end else begin
                    n_rvalid = 1'b0;
                end
                if (r_rvalid && (r_rdata > r_best)) begin
                    n_best = r_rdata;
                    n_pos  = r_ridx;
                end
                if ((r_idx == r_len) && !r_rvalid) begin
                    if (r_best == '0) begin
                        n_energy[r_peak]   = '0;
                        n_position[r_peak] = '0;
                        n_state            = S_NEXT;
                    end else begin
                        n_state = S_LSTART;
                    end
                end
            end

            // start left walk at the peak
            S_LSTART: begin
                n_cur = r_best;
                n_lo  = r_pos;
                n_hi  = r_pos;
                if (r_pos != '0) begin
                    rd_en   = 1'b1;
                    rd_addr = r_pos - AW'(1);
                    n_state = S_WALKL;
                end else begin
                    n_state = S_RSTART;
                end
            end

            // walk left while falling
            S_WALKL: begin
                if (r_cur > r_rdata) begin
                    n_lo  = lo_m1;
                    n_cur = r_rdata;
                    if (lo_m1 != '0) begin
                        rd_en   = 1'b1;
                        rd_addr = lo_m1 - AW'(1);
                    end else begin
                        n_state = S_RSTART;
                    end
                end else begin
                    n_state = S_RSTART;
                end
            end

            // start right walk at the peak
            S_RSTART: begin
                n_cur = r_best;
                if (hi_p1 < r_len) begin
                    rd_en   = 1'b1;
                    rd_addr = hi_p1[AW-1:0];
                    n_state = S_WALKR;
                end else begin
                    n_idx    = CW'(r_lo);
                    n_sum    = '0;
                    n_rvalid = 1'b0;
                    n_state  = S_SUM;
                end
            end

            // walk right while falling
            S_WALKR: begin
                if ((r_cur > r_rdata) && (hi_p2 < r_len)) begin
                    n_hi    = hi_p1[AW-1:0];
                    n_cur   = r_rdata;
                    rd_en   = 1'b1;
                    rd_addr = hi_p2[AW-1:0];
                end else begin
                    if (r_cur > r_rdata) begin
                        n_hi = hi_p1[AW-1:0];
                    end
                    n_idx    = CW'(r_lo);
                    n_sum    = '0;
                    n_rvalid = 1'b0;
                    n_state  = S_SUM;
                end
            end

            // sum energy, clear all bins but the right bound
            S_SUM: begin
                if (r_idx <= CW'(r_hi)) begin
                    rd_en    = 1'b1;
                    rd_addr  = r_idx[AW-1:0];
                    n_idx    = r_idx + CW'(1);
                    n_rvalid = 1'b1;
                    n_ridx   = r_idx[AW-1:0];
                end else begin
                    n_rvalid = 1'b0;
                end
                if (r_rvalid) begin
                    n_sum = (sum_add > SW'(dpsd_pkg::ENERGY_MAX))
                          ? dpsd_pkg::ENERGY_MAX : sum_add[EW-1:0];
                    if (r_ridx != r_hi) begin
                        wr_en   = 1'b1;
                        wr_addr = r_ridx;
                        wr_data = '0;
                    end
                end
                if ((r_idx > CW'(r_hi)) && !r_rvalid) begin
                    n_energy[r_peak]   = r_sum;
                    n_position[r_peak] = r_pos;
                    n_found            = r_found + FW'(1);
                    n_state            = S_NEXT;
                end
            end

            // next peak or decision
            S_NEXT: begin
                if (r_peak == 2'(dpsd_pkg::NUM_PEAKS - 1)) begin
                    n_state = S_DECIDE;
                end else begin
                    n_peak   = r_peak + 2'd1;
                    n_idx    = '0;
                    n_best   = '0;
                    n_pos    = '0;
                    n_rvalid = 1'b0;
                    n_state  = S_SCAN;
                end
            end

            // load result word once the output register is free
            S_DECIDE: begin
                if (!r_m_valid || m_axis_tready) begin
                    n_result.pad             = '0;
                    n_result.detected        = hit;
                    n_result.added_energy    = hit
                        ? ({1'b0, r_energy[0]} + {1'b0, r_energy[1]}) : '0;
                    n_result.first_peak_pos  = dpsd_pkg::POS_OUT_W'(m1);
                    n_result.second_peak_pos = dpsd_pkg::POS_OUT_W'(m2);
                    n_result.peaks_found     = r_found;
                    n_m_valid                = 1'b1;
                    n_state                  = S_LOAD;
                end
            end

            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_LOAD;
            r_cnt     <= '0;
            r_rvalid  <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_rvalid  <= n_rvalid;
            r_m_valid <= n_m_valid;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_len      <= n_len;
        r_peak     <= n_peak;
        r_found    <= n_found;
        r_best     <= n_best;
        r_pos      <= n_pos;
        r_idx      <= n_idx;
        r_ridx     <= n_ridx;
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_cur      <= n_cur;
        r_sum      <= n_sum;
        r_energy   <= n_energy;
        r_position <= n_position;
        r_result   <= n_result;
    end

endmodule

// ----- tb/double_peak_spectrum_detector_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_peak_spectrum_detector_tb
// Streams magnitude spectra into the detector, directed shapes first and then
// random spectra under several sender and receiver idling patterns. An
// in-bench model of the peak extraction predicts each result word, which is
// compared field by field with what the master stream returns.
// ----------------------------------------------------------------------------
module double_peak_spectrum_detector_tb;

    localparam int SPECTRUM_LENGTH = 256;
    localparam int ITEMS_PER_PHASE = 340;
    localparam int MIN_SPECTRA     = 6;
    localparam int HOLD_CYCLES     = 3000;
    localparam int TAIL_CYCLES     = 500;
    localparam int MAX_REPORTS     = 60;
    localparam longint TIMEOUT_NS  = 8_000_000;

    typedef struct {
        logic [dpsd_pkg::MAG_W-1:0] magnitude;
        logic                       last_sample;
    } t_sample;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [dpsd_pkg::S_TDATA_W-1:0] s_axis_tdata = '0;   // magnitude[15:0]
    logic                           s_axis_tlast = 1'b0; // last sample
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    // detected[0], added_energy[25:1], first_peak_pos[33:26],
    // second_peak_pos[41:34], peaks_found[43:42]
    logic [dpsd_pkg::M_TDATA_W-1:0] m_axis_tdata;

    // stimulus and scoreboard state
    t_sample            pending_words[$];
    dpsd_pkg::t_result  results_due[$];
    int unsigned words_queued   = 0;
    int unsigned words_accepted = 0;
    int unsigned mismatches     = 0;
    int unsigned src_idle_pct   = 0;
    int unsigned sink_stall_pct = 0;
    int unsigned hold_requests  = 0;
    int unsigned holds_served   = 0;
    int unsigned hold_left      = 0;
    logic        word_taken     = 1'b0;

    // model copy of the sample memory
    logic [dpsd_pkg::MAG_W-1:0] spec_bins [SPECTRUM_LENGTH];
    int unsigned                bins_loaded = 0;

    double_peak_spectrum_detector #(
        .SPECTRUM_LENGTH(SPECTRUM_LENGTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("double_peak_spectrum_detector_tb: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------
    // peak extraction model
    // ------------------------------------------------------------------

    // pull out the strongest remaining peak of bins 0..len-1
    task automatic extract_peak(input int unsigned len, output int unsigned energy,
                                output int unsigned pos, output bit found);
        int unsigned best;
        int unsigned lo;
        int unsigned hi;
        best   = 0;
        pos    = 0;
        energy = 0;
        for (int unsigned i = 0; i < len; i++) begin
            if (spec_bins[i] > best) begin
                best = spec_bins[i];
                pos  = i;
            end
        end
        found = (best != 0);
        if (found) begin
            lo = pos;
            hi = pos;
            // edge is tested before the neighbor is read
            while (lo > 0 && spec_bins[lo] > spec_bins[lo-1])
                lo--;
            while (hi + 1 < len && spec_bins[hi] > spec_bins[hi+1])
                hi++;
            for (int unsigned i = lo; i <= hi; i++) begin
                energy += spec_bins[i];
                if (energy > dpsd_pkg::ENERGY_MAX)
                    energy = dpsd_pkg::ENERGY_MAX;
            end
            // right bound stays
            for (int unsigned i = lo; i < hi; i++)
                spec_bins[i] = '0;
        end
    endtask

    // three extractions and the double peak decision
    task automatic predict_spectrum();
        int unsigned       len;
        int unsigned       energy[3];
        int unsigned       pos[3];
        int unsigned       found_cnt;
        int unsigned       spread;
        int unsigned       nearest;
        bit                got;
        bit                hit;
        dpsd_pkg::t_result res;
        len         = bins_loaded;
        bins_loaded = 0;
        found_cnt   = 0;
        for (int k = 0; k < dpsd_pkg::NUM_PEAKS; k++) begin
            extract_peak(len, energy[k], pos[k], got);
            if (got)
                found_cnt++;
        end
        hit = 1'b0;
        if (energy[0] < 2 * energy[1] && energy[1] > 2 * energy[2]) begin
            spread  = (pos[0] > pos[1]) ? pos[0] - pos[1] : pos[1] - pos[0];
            nearest = (pos[0] < pos[1]) ? pos[0] : pos[1];
            hit = (nearest != 0) && (2 * spread < 3 * nearest) && (3 * spread > 2 * nearest);
        end
        res = '0;
        res.detected        = hit;
        res.added_energy    = hit ? dpsd_pkg::SUM_W'(energy[0] + energy[1]) : '0;
        res.first_peak_pos  = dpsd_pkg::POS_OUT_W'(pos[0]);
        res.second_peak_pos = dpsd_pkg::POS_OUT_W'(pos[1]);
        res.peaks_found     = dpsd_pkg::FOUND_W'(found_cnt);
        results_due.push_back(res);
    endtask

    // one accepted input word
    task automatic predict_word(input logic [dpsd_pkg::MAG_W-1:0] mag, input logic last);
        if (bins_loaded < SPECTRUM_LENGTH) begin
            spec_bins[bins_loaded] = mag;
            bins_loaded++;
        end
        if (last)
            predict_spectrum();
    endtask

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    // ------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------

    // drive the slave stream from the pending queue
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || word_taken) begin
            if (pending_words.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= pending_words[0].magnitude;
                s_axis_tlast  <= pending_words[0].last_sample;
                void'(pending_words.pop_front());
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver side
    // ------------------------------------------------------------------

    // ready with random stalls, or a long hold when one is requested
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (holds_served != hold_requests) begin
            holds_served  <= hold_requests;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // monitor: predict on input words, compare on output words
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        dpsd_pkg::t_result seen;
        dpsd_pkg::t_result want;
        if (!i_rst_n) begin
            word_taken <= 1'b0;
        end else begin
            word_taken <= s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && s_axis_tready) begin
                words_accepted++;
                predict_word(s_axis_tdata[dpsd_pkg::MAG_W-1:0], s_axis_tlast);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                seen = dpsd_pkg::t_result'(m_axis_tdata);
                if (results_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: unexpected result word, expected none, got %h",
                                 $time, m_axis_tdata);
                end else begin
                    want = results_due.pop_front();
                    check_field("detected", want.detected, seen.detected);
                    check_field("added_energy", want.added_energy, seen.added_energy);
                    check_field("first_peak_pos", want.first_peak_pos, seen.first_peak_pos);
                    check_field("second_peak_pos", want.second_peak_pos,
                                seen.second_peak_pos);
                    check_field("peaks_found", want.peaks_found, seen.peaks_found);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    task automatic push_word(input int unsigned mag, input bit last);
        t_sample w;
        w.magnitude   = dpsd_pkg::MAG_W'(mag);
        w.last_sample = last;
        pending_words.push_back(w);
        words_queued++;
    endtask

    task automatic push_shape(input int shape[$]);
        for (int i = 0; i < shape.size(); i++)
            push_word(shape[i], i == shape.size() - 1);
    endtask

    // random spectrum, mostly two bumps with a matched spread
    task automatic add_random_spectrum(output int unsigned words);
        int mode;
        int len;
        int m1;
        int m2;
        int m3;
        int spread;
        int h1;
        int h2;
        int h3;
        int s1;
        int s2;
        int s3;
        int floor_max;
        int v;
        int t;
        int tmp;
        int shape[$];
        mode = $urandom_range(99);
        if (mode < 58) begin
            len = $urandom_range(12, 64);
            m1  = $urandom_range(2, len / 3);
            if ($urandom_range(3) != 0)
                spread = $urandom_range((2 * m1) / 3 + 1, (3 * m1 + 1) / 2 - 1);
            else
                spread = $urandom_range(1, 2 * m1);
            m2 = m1 + spread;
            if (m2 > len - 1)
                m2 = len - 1;
            h1 = $urandom_range(256, 65535);
            h2 = h1 * $urandom_range(45, 100) / 100;
            if ($urandom_range(1)) begin
                tmp = h1;
                h1  = h2;
                h2  = tmp;
            end
            s1 = h1 / $urandom_range(1, 5) + 1;
            s2 = h2 / $urandom_range(1, 5) + 1;
            m3 = $urandom_range(0, len - 1);
            h3 = $urandom_range(1) ? h2 / $urandom_range(2, 9) : 0;
            s3 = h3 / $urandom_range(1, 3) + 1;
            case ($urandom_range(3))
                0: floor_max = 0;
                1: floor_max = 3;
                2: floor_max = 63;
                default: floor_max = 1023;
            endcase
            for (int i = 0; i < len; i++) begin
                v = $urandom_range(0, floor_max);
                t = h1 - s1 * ((i > m1) ? i - m1 : m1 - i);
                if (t > v) v = t;
                t = h2 - s2 * ((i > m2) ? i - m2 : m2 - i);
                if (t > v) v = t;
                t = h3 - s3 * ((i > m3) ? i - m3 : m3 - i);
                if (t > v) v = t;
                shape.push_back(v);
            end
        end else if (mode < 72) begin
            // full range noise
            len = $urandom_range(1, 40);
            for (int i = 0; i < len; i++)
                shape.push_back($urandom_range(65535));
        end else if (mode < 84) begin
            // small values, many ties and flat tops
            len = $urandom_range(1, 30);
            for (int i = 0; i < len; i++)
                shape.push_back($urandom_range(3));
        end else if (mode < 95) begin
            // sparse, mostly zero
            len = $urandom_range(1, 48);
            for (int i = 0; i < len; i++)
                shape.push_back(($urandom_range(3) == 0) ? $urandom_range(65535) : 0);
        end else if (mode < 98) begin
            // near full length store, noise or a flat maximum
            len = $urandom_range(200, SPECTRUM_LENGTH);
            tmp = $urandom_range(1);
            for (int i = 0; i < len; i++)
                shape.push_back(tmp ? 65535 : $urandom_range(65535));
        end else begin
            // more words than the store holds
            len = $urandom_range(SPECTRUM_LENGTH + 1, SPECTRUM_LENGTH + 40);
            for (int i = 0; i < len; i++)
                shape.push_back($urandom_range(65535));
        end
        push_shape(shape);
        words = len;
    endtask

    task automatic run_random_phase(input int unsigned idle_pct, input int unsigned stall_pct);
        int unsigned words;
        int unsigned total;
        int unsigned spectra;
        src_idle_pct   = idle_pct;
        sink_stall_pct = stall_pct;
        total   = 0;
        spectra = 0;
        while (total < ITEMS_PER_PHASE || spectra < MIN_SPECTRA) begin
            add_random_spectrum(words);
            total += words;
            spectra++;
        end
        wait_idle();
    endtask

    // sender holds back until every word is in and every result is out
    task automatic wait_idle();
        while (words_accepted != words_queued || results_due.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        int shape[$];
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: single bins, flat top, edges, a hand-made double peak
        shape = '{0};
        push_shape(shape);
        shape = '{65535};
        push_shape(shape);
        shape = '{5, 5, 5};
        push_shape(shape);
        shape = '{0, 0, 1, 5, 9, 5, 1, 0, 6, 8, 6, 1};
        push_shape(shape);
        shape = '{9, 4, 1, 7};
        push_shape(shape);
        shape = '{1, 3, 8};
        push_shape(shape);
        wait_idle();

        run_random_phase(0, 0);
        run_random_phase(86, 0);
        run_random_phase(0, 86);
        run_random_phase(26, 26);

        // long receiver hold while spectra keep coming, input must back up
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_requests++;
        for (int n = 0; n < 4; n++) begin
            shape.delete();
            for (int i = 0; i < 20; i++)
                shape.push_back($urandom_range(65535));
            push_shape(shape);
        end
        wait_idle();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && results_due.size() == 0)
            $display("double_peak_spectrum_detector_tb: done, clean");
        else
            $display("double_peak_spectrum_detector_tb: done, errors");
        $finish;
    end

endmodule

// ----- double_peak_spectrum_detector.f -----
rtl/core/dpsd_pkg.sv
rtl/core/double_peak_spectrum_detector.sv
tb/double_peak_spectrum_detector_tb.sv
